// File: rtl/button_press_classifier_assert.svh
// Assertion macros for the button press classifier.
`ifndef BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`ifndef SYNTHESIS
`define BPC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("button press classifier check failed");
`define BPC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("button press classifier check failed");
`else
`define BPC_ASSERT_IMP(lbl, ante, cons)
`define BPC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/bpc_pkg.sv
// Shared types and constants for the button press classifier.
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int CNT_W     = 16;
    localparam int CFG_IDX_W = 1;

    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cnt_t CNT_MAX           = 16'hFFFF;
    localparam cnt_t LONG_PRESS_RESET  = 16'd600;
    localparam cnt_t RELEASE_GAP_RESET = 16'd100;

    localparam cfg_idx_t CFG_LONG_PRESS  = 1'b0;
    localparam cfg_idx_t CFG_RELEASE_GAP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_CONFIRM = 3'd1,
        ST_HELD    = 3'd2,
        ST_WAIT    = 3'd3,
        ST_SECOND  = 3'd4
    } state_t;

    typedef enum logic [1:0] {
        KIND_CLICK  = 2'd0,
        KIND_LONG   = 2'd1,
        KIND_DOUBLE = 2'd2
    } kind_t;

    typedef struct packed {
        logic  fire;
        kind_t kind;
    } result_t;

    function automatic cnt_t sat_inc(cnt_t v);
        return (v == CNT_MAX) ? v : cnt_t'(v + 1'b1);
    endfunction

endpackage

// File: rtl/bpc_fsm.sv
// Press state machine with held and gap counters and the classification decision.
`timescale 1ns / 1ps

module bpc_fsm (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             pressed,
    input  bpc_pkg::cnt_t    long_press_ticks,
    input  bpc_pkg::cnt_t    release_gap_ticks,
    output bpc_pkg::result_t result
);
    import bpc_pkg::*;

    state_t state_reg;
    state_t state_next;
    cnt_t   held_reg;
    cnt_t   held_next;
    cnt_t   gap_reg;
    cnt_t   gap_next;
    cnt_t   gap_inc;
    logic   gap_done;
    kind_t  single_kind;

    assign gap_inc     = sat_inc(gap_reg);
    assign gap_done    = (gap_inc >= release_gap_ticks);
    assign single_kind = (held_reg >= long_press_ticks) ? KIND_LONG : KIND_CLICK;

    always_comb
    begin
        state_next = state_reg;
        held_next  = held_reg;
        gap_next   = gap_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pressed)
                begin
                    state_next = ST_CONFIRM;
                end
            end
            ST_CONFIRM:
            begin
                state_next = pressed ? ST_HELD : ST_IDLE;
            end
            ST_HELD:
            begin
                if (pressed)
                begin
                    held_next = sat_inc(held_reg);
                end
                else
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (pressed)
                begin
                    state_next = ST_SECOND;
                    gap_next   = '0;
                end
                else if (gap_done)
                begin
                    state_next = ST_IDLE;
                    held_next  = '0;
                    gap_next   = '0;
                end
                else
                begin
                    gap_next = gap_inc;
                end
            end
            ST_SECOND:
            begin
                if (pressed)
                begin
                    gap_next = gap_inc;
                end
                else
                begin
                    state_next = ST_IDLE;
                    held_next  = '0;
                    gap_next   = '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                held_next  = '0;
                gap_next   = '0;
            end
        endcase
    end

    always_comb
    begin
        result.fire = 1'b0;
        result.kind = single_kind;
        unique case (state_reg)
            ST_WAIT:
            begin
                result.fire = !pressed && gap_done && (held_reg != '0);
            end
            ST_SECOND:
            begin
                if (!pressed)
                begin
                    if (gap_reg != '0)
                    begin
                        result.fire = 1'b1;
                        result.kind = KIND_DOUBLE;
                    end
                    else
                    begin
                        result.fire = (held_reg != '0);
                    end
                end
            end
            default:
            begin
                result.fire = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            held_reg  <= '0;
            gap_reg   <= '0;
        end
        else if (step)
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            gap_reg   <= gap_next;
        end
    end

endmodule

// File: rtl/button_press_classifier.sv
// Top level of the button press classifier: beat registers, configuration and checks.
//
//   Channel   Signals                                   Beat
//   input     in_valid, in_ready, button_level          one scan tick
//   output    out_valid, out_ready, press_kind          one classified press
//   config    cfg_write_en, cfg_index, cfg_data         one register write
//
// One tick is accepted every cycle unless a stalled output holds in_ready low.
// The tick sits in an input register, the state machine steps, and a result lands
// in the output register. Reset clears the state and counters and loads the
// thresholds with 600 and 100 ticks. Only a result that meets a full, stalled
// output register holds the input register and drops in_ready.
`timescale 1ns / 1ps
`include "button_press_classifier_assert.svh"

module button_press_classifier (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               button_level,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         press_kind,
    input  logic               cfg_write_en,
    input  bpc_pkg::cfg_idx_t  cfg_index,
    input  bpc_pkg::cnt_t      cfg_data
);
    import bpc_pkg::*;

    logic    in_vld_reg;
    logic    level_reg;
    logic    out_vld_reg;
    kind_t   out_kind_reg;
    cnt_t    long_press_reg;
    cnt_t    release_gap_reg;
    logic    advance;
    result_t result;

    bpc_fsm u_fsm (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (advance),
        .pressed           (!level_reg),
        .long_press_ticks  (long_press_reg),
        .release_gap_ticks (release_gap_reg),
        .result            (result)
    );

    assign advance    = in_vld_reg && (!result.fire || !out_vld_reg || out_ready);
    assign in_ready   = !in_vld_reg || advance;
    assign out_valid  = out_vld_reg;
    assign press_kind = out_kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg  <= LONG_PRESS_RESET;
            release_gap_reg <= RELEASE_GAP_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_LONG_PRESS:  long_press_reg  <= cfg_data;
                CFG_RELEASE_GAP: release_gap_reg <= cfg_data;
                default:         long_press_reg  <= long_press_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            level_reg <= button_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance && result.fire)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.fire)
        begin
            out_kind_reg <= result.kind;
        end
    end

    `BPC_ASSERT_NXT(a_result_loads, advance && result.fire, out_valid)
    `BPC_ASSERT_IMP(a_stall_from_output, in_vld_reg && !in_ready, out_vld_reg && !out_ready)
    `BPC_ASSERT_NXT(a_result_drains, advance && !result.fire && out_vld_reg && out_ready, !out_valid)

endmodule
